// File: hw/rtl/relocation_run_decoder_assert.svh
// Assertion macros shared by the relocation run decoder RTL
`ifndef RELOCATION_RUN_DECODER_ASSERT_SVH
`define RELOCATION_RUN_DECODER_ASSERT_SVH

// Condition implies consequence in the same cycle, outside reset
`define RRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle, outside reset
`define RRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rrd_pkg.sv
// Types and constants of the relocation run decoder
`default_nettype none

package rrd_pkg;

  localparam int WORD_POS_W = 23;
  localparam int COUNT_W    = 8;
  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WORD_POS_W-1:0] MAX_WORDS    = 23'd4194304;
  localparam logic [COUNT_W-1:0]    RUN_CONTINUE = 8'hff;

  typedef enum logic [1:0] {
    PHASE_END_CHECK  = 2'd0,
    PHASE_COUNT      = 2'd1,
    PHASE_AFTER_FULL = 2'd2
  } scan_phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELOCATION_BASE = 2'd0,
    CFG_OBJECT_WORDS    = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic                  fix_mode;
    scan_phase_t           scan_phase;
    logic [WORD_POS_W-1:0] word_position;
    logic                  table_done;
  } dec_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  add_value;
    logic [COUNT_W-1:0] word_count;
    logic [ADDR_W-1:0]  patch_address;
    logic               table_end;
    logic               range_error;
  } dec_result_t;

  localparam dec_state_t STATE_CLEAR = '{
    fix_mode:      1'b0,
    scan_phase:    PHASE_END_CHECK,
    word_position: '0,
    table_done:    1'b0
  };

endpackage

`default_nettype wire

// File: hw/rtl/rrd_step.sv
// Decode of one table byte: next decoder state and an optional result
`default_nettype none

module rrd_step
  import rrd_pkg::*;
(
  input  dec_state_t             state,
  input  logic [COUNT_W-1:0]     table_byte,
  input  logic                   start_table,
  input  logic [ADDR_W-1:0]      relocation_base,
  input  logic [WORD_POS_W-1:0]  object_words,
  output dec_state_t             state_next,
  output logic                   res_valid,
  output dec_result_t            res
);

  dec_state_t             cur;
  logic [WORD_POS_W-1:0]  pos_sum;
  logic [WORD_POS_W-1:0]  pos_sat;
  logic [WORD_POS_W-1:0]  limit;
  logic                   do_count;

  // Clear first on a table start
  assign cur = start_table ? STATE_CLEAR : state;

  // Run end position, clamped size limit and saturated position
  assign pos_sum = cur.word_position + WORD_POS_W'(table_byte);
  assign limit   = (object_words < MAX_WORDS) ? object_words : MAX_WORDS;
  assign pos_sat = (pos_sum > MAX_WORDS) ? MAX_WORDS : pos_sum;

  // Pick the action for this phase
  always_comb begin
    state_next = cur;
    res_valid  = 1'b0;
    res        = '0;
    do_count   = 1'b0;
    if (!cur.table_done) begin
      case (cur.scan_phase)
        PHASE_END_CHECK: begin
          if (table_byte == '0) begin
            state_next.table_done = 1'b1;
            res_valid             = 1'b1;
            res.table_end         = 1'b1;
          end else begin
            do_count = 1'b1;
          end
        end
        PHASE_AFTER_FULL: begin
          if (table_byte == '0) begin
            state_next.fix_mode   = ~cur.fix_mode;
            state_next.scan_phase = PHASE_COUNT;
          end else begin
            do_count = 1'b1;
          end
        end
        default: do_count = 1'b1;
      endcase
    end

    // Count byte: emit a fix run for a nonzero fix count, advance position, handle continuation
    if (do_count) begin
      if (cur.fix_mode && table_byte != '0) begin
        res_valid         = 1'b1;
        res.patch_address = relocation_base
                            + ADDR_W'({cur.word_position, 2'b00});
        res.word_count    = table_byte;
        res.add_value     = relocation_base;
        res.range_error   = (pos_sum > limit);
      end
      state_next.word_position = pos_sat;
      if (table_byte == RUN_CONTINUE) begin
        state_next.scan_phase = PHASE_AFTER_FULL;
      end else begin
        state_next.fix_mode   = ~cur.fix_mode;
        state_next.scan_phase = PHASE_END_CHECK;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/relocation_run_decoder.sv
// Top level of the relocation run decoder
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata = table_byte, s_tuser = start_table
//  m_*      out  m_tvalid/m_tready   m_tdata = patch/count/add, m_tlast, m_tuser
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One table byte per cycle while the output is not stalled: each byte is held in
// the input register, is decoded there and its result, if any, lands in the
// output register.
// rst clears the decoder state, both valid flags and the configuration registers.
// A stalled output holds the input register, which then drops s_tready.
// cfg_ready is always high.
`default_nettype none

module relocation_run_decoder
  import rrd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // table_byte [7:0]
  input  wire logic [COUNT_W-1:0]    s_tdata,
  // start_table [0]
  input  wire logic                  s_tuser,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // patch_address [31:0], word_count [39:32], add_value [71:40]
  output logic [2*ADDR_W+COUNT_W-1:0] m_tdata,
  // range_error [0]
  output logic                       m_tuser,
  output logic                       m_tlast,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ADDR_W-1:0]     cfg_data
);

  logic [ADDR_W-1:0]     relocation_base;
  logic [WORD_POS_W-1:0] object_words;

  logic                  in_valid;
  logic [COUNT_W-1:0]    in_byte;
  logic                  in_start;
  logic                  advance;

  dec_state_t            state;
  dec_state_t            state_next;
  logic                  step_valid;
  dec_result_t           step_res;
  dec_result_t           out_res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      relocation_base <= '0;
      object_words    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RELOCATION_BASE: relocation_base <= cfg_data;
        CFG_OBJECT_WORDS:    object_words    <= cfg_data[WORD_POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: advance when the output register can take a result
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  // Decode the held byte
  rrd_step u_step (
    .state           (state),
    .table_byte      (in_byte),
    .start_table     (in_start),
    .relocation_base (relocation_base),
    .object_words    (object_words),
    .state_next      (state_next),
    .res_valid       (step_valid),
    .res             (step_res)
  );

  // Commit decoder state when the byte leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (in_valid && advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && step_valid) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {out_res.add_value, out_res.word_count, out_res.patch_address};
  assign m_tlast = out_res.table_end;
  assign m_tuser = out_res.range_error;

  `include "relocation_run_decoder_assert.svh"

  `RRD_ASSERT_NOW(a_end_payload_zero, m_tvalid && m_tlast,
                  m_tdata == '0 && !m_tuser, "end result carries a payload")
  `RRD_ASSERT_NOW(a_position_bound, 1'b1, state.word_position <= MAX_WORDS,
                  "word position beyond saturation limit")
  `RRD_ASSERT_NOW(a_done_silent, in_valid && !in_start && state.table_done,
                  !step_valid, "result produced after table end")
  `RRD_ASSERT_NEXT(a_stall_holds_input, in_valid && !advance,
                   in_valid && $stable(in_byte) && $stable(state),
                   "input register changed during output stall")

endmodule

`default_nettype wire

// File: verif/patch_run_checker.sv
// Predicts the decoder's patch runs from the observed channels and compares them
`timescale 1ns / 100ps

module patch_run_checker
  import rrd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic [COUNT_W-1:0]          s_tdata,
  input  logic                        s_tuser,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [2*ADDR_W+COUNT_W-1:0] m_tdata,
  input  logic                        m_tuser,
  input  logic                        m_tlast,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [ADDR_W-1:0]           cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          runs_checked
);

  // Register copies
  logic [ADDR_W-1:0]     load_base;
  logic [WORD_POS_W-1:0] size_words;

  // Decoder state copy
  logic                  in_fix_run;
  scan_phase_t           phase;
  logic [WORD_POS_W-1:0] word_pos;
  logic                  finished;

  // Patch runs predicted but not yet seen on the output
  dec_result_t patch_runs_due[$];

  function automatic void restart_table();
    in_fix_run = 1'b0;
    phase      = PHASE_END_CHECK;
    word_pos   = '0;
    finished   = 1'b0;
  endfunction

  // Apply one run count: emit a patch run for a nonzero fix count, then move on
  function automatic void take_count(input logic [COUNT_W-1:0] count);
    logic [WORD_POS_W:0]   reach;
    logic [WORD_POS_W-1:0] bound;
    dec_result_t           run;
    reach = {1'b0, word_pos} + (WORD_POS_W+1)'(count);
    bound = (size_words < MAX_WORDS) ? size_words : MAX_WORDS;
    if (in_fix_run && count != '0) begin
      run               = '0;
      run.patch_address = load_base + ADDR_W'({word_pos, 2'b00});
      run.word_count    = count;
      run.add_value     = load_base;
      run.range_error   = (reach > bound);
      patch_runs_due.push_back(run);
    end
    // saturate the position at the largest object size
    word_pos = (reach > MAX_WORDS) ? MAX_WORDS : reach[WORD_POS_W-1:0];
    if (count == RUN_CONTINUE) begin
      phase = PHASE_AFTER_FULL;
    end else begin
      in_fix_run = ~in_fix_run;
      phase      = PHASE_END_CHECK;
    end
  endfunction

  function automatic void decode_table_byte(input logic [COUNT_W-1:0] tbyte,
                                            input logic first);
    dec_result_t mark;
    if (first) restart_table();
    if (!finished) begin
      case (phase)
        PHASE_END_CHECK: begin
          // a zero where a run would begin closes the table
          if (tbyte == '0) begin
            finished       = 1'b1;
            mark           = '0;
            mark.table_end = 1'b1;
            patch_runs_due.push_back(mark);
          end else begin
            take_count(tbyte);
          end
        end
        PHASE_AFTER_FULL: begin
          // zero after a full run switches kind early
          if (tbyte == '0) begin
            in_fix_run = ~in_fix_run;
            phase      = PHASE_COUNT;
          end else begin
            take_count(tbyte);
          end
        end
        default: take_count(tbyte);
      endcase
    end
  endfunction

  task automatic check_result();
    dec_result_t want;
    dec_result_t got;
    got.patch_address = m_tdata[ADDR_W-1:0];
    got.word_count    = m_tdata[ADDR_W+COUNT_W-1:ADDR_W];
    got.add_value     = m_tdata[2*ADDR_W+COUNT_W-1:ADDR_W+COUNT_W];
    got.table_end     = m_tlast;
    got.range_error   = m_tuser;
    if (patch_runs_due.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected result: addr %h count %0d add %h end %b range %b",
                 got.patch_address, got.word_count, got.add_value,
                 got.table_end, got.range_error);
      fail_count++;
    end else begin
      want = patch_runs_due.pop_front();
      runs_checked++;
      if (got !== want) begin
        if (fail_count < 10)
          $display("result %0d wrong: expected addr %h count %0d add %h end %b range %b, %s",
                   runs_checked, want.patch_address, want.word_count, want.add_value,
                   want.table_end, want.range_error,
                   $sformatf("got addr %h count %0d add %h end %b range %b",
                             got.patch_address, got.word_count, got.add_value,
                             got.table_end, got.range_error));
        fail_count++;
      end
    end
  endtask

  // Compare first so a request accepted in the same cycle cannot mask an extra result
  always @(posedge clk) begin
    if (rst) begin
      load_base    = '0;
      size_words   = '0;
      fail_count   = 0;
      runs_checked = 0;
      restart_table();
      patch_runs_due.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RELOCATION_BASE: load_base = cfg_data;
          CFG_OBJECT_WORDS:    size_words = cfg_data[WORD_POS_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) decode_table_byte(s_tdata, s_tuser);
    end
    pending = patch_runs_due.size();
  end

endmodule

// File: verif/relocation_run_decoder_test.sv
// Stimulus, flow control and verdict for the relocation run decoder
`timescale 1ns / 100ps

module relocation_run_decoder_test;
  import rrd_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int LONG_HOLD     = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 230;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [COUNT_W-1:0]   NIL_COUNT    = 8'd0;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic [COUNT_W-1:0]          s_tdata   = '0;
  logic                        s_tuser   = 1'b0;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  logic [2*ADDR_W+COUNT_W-1:0] m_tdata;
  logic                        m_tuser;
  logic                        m_tlast;
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [ADDR_W-1:0]           cfg_data  = '0;

  int fail_count;
  int pending;
  int runs_checked;
  int items_sent    = 0;
  int settings_used = 0;
  bit steady        = 1'b0;
  int holds_asked   = 0;
  int holds_given   = 0;

  relocation_run_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  patch_run_checker run_check (
    .clk          (clk),
    .rst          (rst),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .runs_checked (runs_checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("end of test: mismatches");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when asked
  initial begin : result_sink
    int gap;
    @(negedge clk);
    forever begin
      if (holds_given < holds_asked) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_given++;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  // Offer one request after a random gap; valid stays up on return
  task automatic send_byte(input logic [COUNT_W-1:0] tbyte, input logic first);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= tbyte;
    s_tuser  <= first;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and wait out every expected result and the pipeline
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
  endtask

  // Load both registers in random order while idle; upper data bits are junk for the size
  task automatic apply_setting(input logic [ADDR_W-1:0] base,
                               input logic [WORD_POS_W-1:0] words);
    logic [ADDR_W-1:0] word_data;
    word_data                   = $urandom;
    word_data[WORD_POS_W-1:0]   = words;
    settle();
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CFG_RELOCATION_BASE, base);
      write_reg(CFG_OBJECT_WORDS, word_data);
    end else begin
      write_reg(CFG_OBJECT_WORDS, word_data);
      write_reg(CFG_RELOCATION_BASE, base);
    end
    // unmapped index must leave both registers alone
    write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Well-formed table with random counts, closed by a plain count and a zero
  task automatic send_table(input int body_len, input bit fresh);
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] last_count;
    int                 pick;
    last_count = NIL_COUNT;
    for (int i = 0; i < body_len; i++) begin
      pick = $urandom_range(0, 99);
      if (last_count == RUN_CONTINUE && pick < 15)
        count = NIL_COUNT;
      else if (pick < 27)
        count = RUN_CONTINUE;
      else if (pick < 29)
        count = NIL_COUNT;
      else if (pick < 40)
        count = COUNT_W'($urandom_range(1, 3));
      else
        count = COUNT_W'($urandom_range(1, 254));
      send_byte(count, fresh && i == 0);
      last_count = count;
    end
    send_byte(COUNT_W'($urandom_range(1, 254)), 1'b0);
    send_byte(NIL_COUNT, 1'b0);
    // trailing bytes past the end are ignored
    repeat ($urandom_range(0, 2)) send_byte(COUNT_W'($urandom), 1'b0);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_byte(COUNT_W'($urandom), $urandom_range(0, 3) == 0);
  endtask

  initial begin : stimulus
    int start_item;
    bit hold_done;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset registers, table begun without a start flag, byte after the end
    send_byte(8'd3, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(NIL_COUNT, 1'b0);
    send_byte(8'd9, 1'b0);

    apply_setting(32'hFFFF_FFFC, 23'd100);
    // empty table
    send_byte(NIL_COUNT, 1'b1);
    // early switch into fix, zero fix count, full fix runs, close before a fix run
    send_byte(RUN_CONTINUE, 1'b1);
    send_byte(NIL_COUNT, 1'b0);
    send_byte(NIL_COUNT, 1'b0);
    send_byte(8'd4, 1'b0);
    send_byte(RUN_CONTINUE, 1'b0);
    send_byte(RUN_CONTINUE, 1'b0);
    send_byte(NIL_COUNT, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(NIL_COUNT, 1'b0);
    // run ending exactly at the object size, then one beyond it
    send_byte(8'd1, 1'b1);
    send_byte(8'd99, 1'b0);
    send_byte(8'd3, 1'b0);
    send_byte(8'd254, 1'b0);
    send_byte(NIL_COUNT, 1'b0);
    send_byte(8'd5, 1'b0);
    send_byte(RUN_CONTINUE, 1'b0);
    // restart in the middle of a table, early switch back into skip
    send_byte(8'd7, 1'b1);
    send_byte(8'd3, 1'b0);
    send_byte(8'd2, 1'b1);
    send_byte(RUN_CONTINUE, 1'b0);
    send_byte(NIL_COUNT, 1'b0);
    send_byte(NIL_COUNT, 1'b0);
    send_byte(NIL_COUNT, 1'b0);

    // Random tables under a spread of register settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_setting(32'h0000_0000, 23'd0);
        1: apply_setting(32'hFFFF_FFFF, MAX_WORDS);
        2: apply_setting($urandom & 32'hFFFF_FFFC,
                         WORD_POS_W'($urandom_range(4194305, 8388607)));
        3: apply_setting($urandom, WORD_POS_W'($urandom_range(1, 6000)));
        4: apply_setting(32'hFFFF_F000, WORD_POS_W'($urandom_range(200, 2000)));
        default: apply_setting($urandom, WORD_POS_W'($urandom_range(500, 20000)));
      endcase
      start_item = items_sent;
      hold_done  = 1'b0;
      while (items_sent - start_item < PHASE_ITEMS) begin
        if (!hold_done && items_sent - start_item >= PHASE_ITEMS / 2) begin
          holds_asked++;
          hold_done  = 1'b1;
        end
        steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 85)
          send_table($urandom_range(1, 40), $urandom_range(0, 9) != 0);
        else
          send_noise($urandom_range(1, 10));
      end
      steady = 1'b0;
    end

    settle();
    $display("sent %0d table bytes under %0d register settings, checked %0d results",
             items_sent, settings_used, runs_checked);
    $display("covered empty tables, early kind switches, restarts, bytes past the end, %s",
             "range limits and size clamping");
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
